// ===== rtl/core/radio_frame_channel_rewriter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame channel rewriter
// Both macros sample on i_clk and are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RADIO_FRAME_CHANNEL_REWRITER_ASSERT_SVH
`define RADIO_FRAME_CHANNEL_REWRITER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RFCR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rfcr assertion failed");

// Consequent checked in the cycle after the antecedent.
`define RFCR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rfcr assertion failed");

`endif

// ===== rtl/core/rfcr_pkg.sv =====
// ----------------------------------------------------------------------------
// rfcr_pkg
// Types, constants and helper functions of the frame channel rewriter.
// ----------------------------------------------------------------------------
package rfcr_pkg;

    localparam int BYTE_W  = 8;
    localparam int KEY_W   = 16;
    localparam int CHAN_W  = 12;
    localparam int FPU_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_UPDATE = 2'd1;

    localparam logic [CHAN_W-1:0] SYNC_VALUE_RST   = 12'd2624;
    localparam logic [FPU_W-1:0]  FPU_RST          = 4'd3;
    localparam logic [CHAN_W-1:0] CHANNEL_WORD_RST = 12'd89;

    localparam logic [BYTE_W-1:0] SYNC_B0  = 8'hff;
    localparam logic [BYTE_W-1:0] SYNC_B1  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_B2  = 8'haa;
    localparam logic [BYTE_W-1:0] HDR0_VAL = 8'haa;
    localparam logic [3:0]        HDR1_HI  = 4'ha;

    localparam logic [3:0] SKIP_AFTER_HDR0 = 4'd11;
    localparam logic [3:0] SKIP_AFTER_HDR1 = 4'd10;

    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [CHAN_W-1:0] CH_RAW_MAX = 12'd2719;
    // ceil(2^20 / 17): exact quotient for any 16-bit dividend
    localparam logic [15:0] DIV17_RECIP = 16'd61681;
    localparam logic [5:0]  SPREAD_BIT  = 6'h20;

    typedef enum logic [3:0] {
        PH_WAIT  = 4'd0,
        PH_SYNC2 = 4'd1,
        PH_SYNC3 = 4'd2,
        PH_HDR0  = 4'd3,
        PH_HDR1  = 4'd4,
        PH_CH3HI = 4'd5,
        PH_P6    = 4'd6,
        PH_P7    = 4'd7,
        PH_CH3LO = 4'd8,
        PH_CRCH  = 4'd9,
        PH_CRCL  = 4'd10,
        PH_G1    = 4'd11,
        PH_G2    = 4'd12,
        PH_SUMH  = 4'd13,
        PH_SUML  = 4'd14,
        PH_SKIP  = 4'd15
    } t_phase;

    typedef struct packed {
        logic frame_end;
    } t_frame_evt;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [5:0] absdiff6(input logic [5:0] a, input logic [5:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Set bit 5 of a chunk when that moves it further from the previous one
    function automatic logic [5:0] spread(input logic [5:0] prev, input logic [4:0] cur);
        logic [5:0] alt;
        logic [5:0] plain;
        plain = {1'b0, cur};
        alt   = plain | SPREAD_BIT;
        return (absdiff6(prev, alt) > absdiff6(prev, plain)) ? alt : plain;
    endfunction

    // (2719 - raw) * 16 / 17, saturating at zero
    function automatic logic [CHAN_W-1:0] to_channel(input logic [CHAN_W-1:0] raw);
        logic [CHAN_W-1:0] d;
        logic [15:0]       x;
        logic [31:0]       p;
        d = (raw > CH_RAW_MAX) ? '0 : CH_RAW_MAX - raw;
        x = {d, 4'b0000};
        p = 32'(x) * 32'(DIV17_RECIP);
        return p[31:20];
    endfunction

endpackage

// ===== rtl/core/radio_frame_channel_rewriter.sv =====
// ----------------------------------------------------------------------------
// radio_frame_channel_rewriter
// Byte-for-byte pass-through of a radio frame link that rewrites CH3,
// the CRC and the checksum of good frames.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        sink       i_in_valid/o_in_stall    i_byte_in, i_key_bits
//  out       source     o_out_valid/i_out_stall  o_byte_out
//  cfg       sink       i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
//  One item per cycle sustained while the output is not stalled; an accepted
//  item enters the input register, then frame logic writes the result register.
//  The CH3 value update at frame end goes through a 16x16 reciprocal
//  multiply and sets the length of the combinational path.
//  Synchronous active-low reset; no clearing pass.
//  A stalled output holds its item; the input register still takes one more.
// ----------------------------------------------------------------------------
module radio_frame_channel_rewriter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [rfcr_pkg::BYTE_W-1:0]     i_byte_in,
    input  logic [rfcr_pkg::KEY_W-1:0]      i_key_bits,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [rfcr_pkg::BYTE_W-1:0]     o_byte_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rfcr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfcr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rfcr_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic [KEY_W-1:0]  r_in_keys;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [CHAN_W-1:0] r_sync_value;
    logic [FPU_W-1:0]  r_frames_per_update;

    logic              out_free;
    logic              step;
    logic              in_take;
    logic [BYTE_W-1:0] frame_byte;
    logic [CHAN_W-1:0] channel_word;
    t_frame_evt        evt;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value        <= SYNC_VALUE_RST;
            r_frames_per_update <= FPU_RST;
        end else if (i_cfg_valid) begin
            // drop writes to unknown indexes
            if (i_cfg_index == CFG_SYNC_VALUE)
                r_sync_value <= i_cfg_data;
            else if (i_cfg_index == CFG_FRAMES_PER_UPDATE)
                r_frames_per_update <= i_cfg_data[FPU_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (out_free || !r_in_valid) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_byte_in;
            r_in_keys <= i_key_bits;
        end
    end

    rfcr_frame u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_byte         (r_in_byte),
        .i_channel_word (channel_word),
        .o_byte         (frame_byte),
        .o_evt          (evt)
    );

    rfcr_seq u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_evt               (evt),
        .i_key_bits          (r_in_keys),
        .i_sync_value        (r_sync_value),
        .i_frames_per_update (r_frames_per_update),
        .o_channel_word      (channel_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) r_out_byte <= frame_byte;
    end

    assign o_out_valid = r_out_valid;
    assign o_byte_out  = r_out_byte;

endmodule

// ===== rtl/core/rfcr_frame.sv =====
// ----------------------------------------------------------------------------
// rfcr_frame
// Frame tracker: sync hunt, header check, byte rewrite, CRC and checksum.
// ----------------------------------------------------------------------------
module rfcr_frame (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [rfcr_pkg::BYTE_W-1:0]  i_byte,
    input  logic [rfcr_pkg::CHAN_W-1:0]  i_channel_word,
    output logic [rfcr_pkg::BYTE_W-1:0]  o_byte,
    output rfcr_pkg::t_frame_evt         o_evt
);
    import rfcr_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_skip, n_skip;
    logic [15:0] r_sum, n_sum;
    logic [15:0] r_crc, n_crc;
    logic [BYTE_W-1:0] byte_out;
    logic [3:0]  skip_dec;

    assign skip_dec = r_skip - 4'd1;

    always_comb begin
        n_phase  = r_phase;
        n_skip   = r_skip;
        n_sum    = r_sum;
        n_crc    = r_crc;
        byte_out = i_byte;
        o_evt.frame_end = 1'b0;
        unique case (r_phase)
            PH_WAIT: begin
                if (i_byte == SYNC_B0) n_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (i_byte == SYNC_B1)      n_phase = PH_SYNC3;
                else if (i_byte != SYNC_B0) n_phase = PH_WAIT;
            end
            PH_SYNC3: begin
                if (i_byte == SYNC_B2)      n_phase = PH_HDR0;
                else if (i_byte == SYNC_B0) n_phase = PH_SYNC2;
            end
            PH_HDR0: begin
                if (i_byte == HDR0_VAL) begin
                    n_phase = PH_HDR1;
                end else begin
                    n_phase = PH_SKIP;
                    n_skip  = SKIP_AFTER_HDR0;
                end
                n_sum = {8'h00, i_byte};
                n_crc = crc_byte(16'h0000, i_byte);
            end
            PH_HDR1: begin
                if (i_byte[7:4] == HDR1_HI) begin
                    n_phase = PH_CH3HI;
                end else begin
                    n_phase = PH_SKIP;
                    n_skip  = SKIP_AFTER_HDR1;
                end
                n_sum = r_sum + {8'h00, i_byte};
                n_crc = crc_byte(r_crc, i_byte);
            end
            PH_CH3HI: begin
                byte_out = {i_byte[7:4], i_channel_word[11:8]};
                n_phase  = PH_P6;
                n_sum    = r_sum + {8'h00, byte_out};
                n_crc    = crc_byte(r_crc, byte_out);
            end
            PH_P6: begin
                n_phase = PH_P7;
                n_sum   = r_sum + {8'h00, i_byte};
                n_crc   = crc_byte(r_crc, i_byte);
            end
            PH_P7: begin
                n_phase = PH_CH3LO;
                n_sum   = r_sum + {8'h00, i_byte};
                n_crc   = crc_byte(r_crc, i_byte);
            end
            PH_CH3LO: begin
                byte_out = i_channel_word[7:0];
                n_phase  = PH_CRCH;
                n_sum    = r_sum + {8'h00, byte_out};
                n_crc    = crc_byte(r_crc, byte_out);
            end
            PH_CRCH: begin
                byte_out = r_crc[15:8];
                n_phase  = PH_CRCL;
                n_sum    = r_sum + {8'h00, byte_out};
            end
            PH_CRCL: begin
                byte_out = r_crc[7:0];
                n_phase  = PH_G1;
                n_sum    = r_sum + {8'h00, byte_out};
            end
            PH_G1: n_phase = PH_G2;
            PH_G2: n_phase = PH_SUMH;
            PH_SUMH: begin
                byte_out = r_sum[15:8];
                n_phase  = PH_SUML;
            end
            PH_SUML: begin
                byte_out = r_sum[7:0];
                n_phase  = PH_WAIT;
                o_evt.frame_end = i_step;
            end
            PH_SKIP: begin
                // counts down and returns to hunting once the count reaches zero
                n_skip = skip_dec;
                if (skip_dec == 4'd0) n_phase = PH_WAIT;
            end
        endcase
    end

    assign o_byte = byte_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_skip  <= '0;
            r_sum   <= '0;
            r_crc   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_skip  <= n_skip;
            r_sum   <= n_sum;
            r_crc   <= n_crc;
        end
    end

endmodule

// ===== rtl/core/rfcr_seq.sv =====
// ----------------------------------------------------------------------------
// rfcr_seq
// Channel value sequencer: frame counter, slot index, pending key bits.
// ----------------------------------------------------------------------------
module rfcr_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rfcr_pkg::t_frame_evt         i_evt,
    input  logic [rfcr_pkg::KEY_W-1:0]   i_key_bits,
    input  logic [rfcr_pkg::CHAN_W-1:0]  i_sync_value,
    input  logic [rfcr_pkg::FPU_W-1:0]   i_frames_per_update,
    output logic [rfcr_pkg::CHAN_W-1:0]  o_channel_word
);
    import rfcr_pkg::*;

    logic [CHAN_W-1:0] r_channel_word, n_channel_word;
    logic [FPU_W-1:0]  r_frame_count, n_frame_count;
    logic [1:0]        r_slot, n_slot;
    logic [KEY_W-1:0]  r_pending, n_pending;

    logic [FPU_W-1:0]  count_inc;
    logic              advance;
    logic [5:0]        v1, v2, v3, v_sel;
    logic [CHAN_W-1:0] raw_base, raw_data, raw;
    logic [KEY_W-1:0]  keep_mask;

    assign count_inc = r_frame_count + 4'd1;
    assign advance   = count_inc >= i_frames_per_update;

    assign v1 = r_pending[5:0];
    assign v2 = spread(v1, r_pending[10:6]);
    assign v3 = spread(v2, r_pending[15:11]);

    always_comb begin
        unique case (r_slot)
            2'd0: begin v_sel = '0; keep_mask = 16'hffff; end
            2'd1: begin v_sel = v1; keep_mask = 16'hffc0; end
            2'd2: begin v_sel = v2; keep_mask = 16'hf83f; end
            2'd3: begin v_sel = v3; keep_mask = 16'h07ff; end
        endcase
    end

    assign raw_base = {1'b0, v_sel, 5'b00000} + 12'h020;
    assign raw_data = raw_base + {4'b0000, raw_base[11:8]};
    assign raw      = (r_slot == 2'd0) ? i_sync_value : raw_data;

    always_comb begin
        n_channel_word = r_channel_word;
        n_frame_count  = r_frame_count;
        n_slot         = r_slot;
        n_pending      = r_pending;
        if (i_evt.frame_end) begin
            n_frame_count = count_inc;
            if (advance) begin
                n_frame_count  = '0;
                n_channel_word = to_channel(raw);
                n_slot         = r_slot + 2'd1;
                n_pending      = (r_pending & keep_mask) | i_key_bits;
            end else begin
                n_pending = r_pending | i_key_bits;
            end
        end
    end

    assign o_channel_word = r_channel_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_word <= CHANNEL_WORD_RST;
            r_frame_count  <= '0;
            r_slot         <= '0;
            r_pending      <= '0;
        end else begin
            r_channel_word <= n_channel_word;
            r_frame_count  <= n_frame_count;
            r_slot         <= n_slot;
            r_pending      <= n_pending;
        end
    end

endmodule

// ===== rtl/core/rfcr_checker.sv =====
// ----------------------------------------------------------------------------
// rfcr_checker
// Port-level checks of the frame channel rewriter, bound to the top level.
// ----------------------------------------------------------------------------
`include "radio_frame_channel_rewriter_assert.svh"

module rfcr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [rfcr_pkg::BYTE_W-1:0] o_byte_out
);

    // a stalled result stays on the port
    `RFCR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `RFCR_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_byte_out))

    // input backs up only behind a stalled, full output
    `RFCR_ASSERT_SAME(a_in_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // an accepted item passes the input register and reaches the output once the output is not stalled
    `RFCR_ASSERT_NEXT(a_in_to_out, i_rst_n && i_in_valid && !o_in_stall ##1 i_rst_n && !i_out_stall, o_out_valid)

endmodule

bind radio_frame_channel_rewriter rfcr_checker u_rfcr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_byte_out  (o_byte_out)
);

// ===== dv/tb_radio_frame_channel_rewriter.sv =====
// ----------------------------------------------------------------------------
// tb_radio_frame_channel_rewriter
// Streams bytes through the frame channel rewriter: a directed table of
// sync, header, rewrite and skip cases, then random frames, broken frames
// and noise under several register settings and idle patterns. Every byte
// out is checked against its table value or a cycle-free parser model.
// ----------------------------------------------------------------------------
module tb_radio_frame_channel_rewriter;
    import rfcr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [BYTE_W-1:0] din;
        logic [KEY_W-1:0]  keys;
        logic              known;
        logic [BYTE_W-1:0] dout;
    } t_dir_row;

    // Reset settings: channel word 0x059
    localparam int N_DIR = 26;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{8'h00, 16'h0000, 1'b1, 8'h00},
        '{8'hff, 16'h0000, 1'b1, 8'hff},
        '{8'h12, 16'h0000, 1'b1, 8'h12},   // broken sync, back to hunting
        '{8'hff, 16'h0000, 1'b1, 8'hff},
        '{8'hff, 16'h0000, 1'b1, 8'hff},   // repeated ff keeps first sync byte
        '{8'h55, 16'h0000, 1'b1, 8'h55},
        '{8'hff, 16'h0000, 1'b1, 8'hff},   // ff restarts after 55
        '{8'h55, 16'h0000, 1'b1, 8'h55},
        '{8'h07, 16'h0000, 1'b1, 8'h07},   // third sync byte keeps waiting
        '{8'haa, 16'h0000, 1'b1, 8'haa},
        '{8'haa, 16'h0000, 1'b1, 8'haa},
        '{8'haf, 16'h0000, 1'b1, 8'haf},
        '{8'hf3, 16'h0000, 1'b1, 8'hf0},   // CH3 high nibble replaced
        '{8'h00, 16'h0000, 1'b1, 8'h00},
        '{8'hff, 16'h0000, 1'b1, 8'hff},
        '{8'h7e, 16'h0000, 1'b1, 8'h59},   // CH3 low byte replaced
        '{8'h00, 16'h0000, 1'b0, 8'h00},
        '{8'h00, 16'h0000, 1'b0, 8'h00},
        '{8'hff, 16'h0000, 1'b1, 8'hff},
        '{8'h00, 16'h0000, 1'b1, 8'h00},
        '{8'h00, 16'h0000, 1'b0, 8'h00},
        '{8'h00, 16'hffff, 1'b0, 8'h00},
        '{8'hff, 16'h0000, 1'b1, 8'hff},
        '{8'h55, 16'h0000, 1'b1, 8'h55},
        '{8'haa, 16'h0000, 1'b1, 8'haa},
        '{8'h3c, 16'h0000, 1'b1, 8'h3c}    // bad first header byte
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [BYTE_W-1:0]     i_byte_in;
    logic [KEY_W-1:0]      i_key_bits;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [BYTE_W-1:0]     o_byte_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    radio_frame_channel_rewriter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_byte_in   (i_byte_in),
        .i_key_bits  (i_key_bits),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_byte_out  (o_byte_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Parser model state
    t_phase            rx_phase;
    logic [3:0]        skip_cnt;
    logic [15:0]       sum_run;
    logic [15:0]       crc_run;
    logic [CHAN_W-1:0] ch3_word;
    logic [3:0]        frames_seen;
    logic [1:0]        seq_slot;
    logic [KEY_W-1:0]  key_latch;
    logic [CHAN_W-1:0] sync_raw;
    logic [FPU_W-1:0]  update_every;

    logic [BYTE_W-1:0] expected_bytes [$];
    int                mismatch_cnt = 0;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                quiet_cycles;

    function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [CHAN_W-1:0] raw_to_channel(input logic [15:0] raw);
        logic [31:0] d;
        d = (raw > 16'(CH_RAW_MAX)) ? 32'd0 : 32'(CH_RAW_MAX) - 32'(raw);
        return 12'((d * 32'd16) / 32'd17);
    endfunction

    // Keep bit 5 set only when it moves the chunk further from the last one
    function automatic logic [7:0] spread_chunk(input logic [7:0] prev, input logic [7:0] cur);
        logic [7:0] alt;
        logic [7:0] d_alt;
        logic [7:0] d_cur;
        alt   = cur | 8'(SPREAD_BIT);
        d_alt = (prev >= alt) ? prev - alt : alt - prev;
        d_cur = (prev >= cur) ? prev - cur : cur - prev;
        return (d_alt > d_cur) ? alt : cur;
    endfunction

    function automatic logic [CHAN_W-1:0] next_channel();
        logic [7:0]  v1;
        logic [7:0]  v2;
        logic [7:0]  v3;
        logic [7:0]  vs;
        logic [15:0] raw;
        logic [1:0]  s;
        s  = seq_slot;
        v1 = {2'b00, key_latch[5:0]};
        v2 = spread_chunk(v1, {3'b000, key_latch[10:6]});
        v3 = spread_chunk(v2, {3'b000, key_latch[15:11]});
        // drop the chunk that goes out now
        case (s)
            2'd1: key_latch &= 16'hffc0;
            2'd2: key_latch &= 16'hf83f;
            2'd3: key_latch &= 16'h07ff;
            default: ;
        endcase
        if (s == 2'd0) begin
            raw = {4'h0, sync_raw};
        end else begin
            vs  = (s == 2'd1) ? v1 : (s == 2'd2) ? v2 : v3;
            raw = ({8'h00, vs} << 5) + 16'h0020;
            raw = raw + (raw >> 8);
        end
        seq_slot = s + 2'd1;
        return raw_to_channel(raw);
    endfunction

    function automatic logic [BYTE_W-1:0] rewrite_byte(input logic [BYTE_W-1:0] b_in,
                                                       input logic [KEY_W-1:0] keys);
        logic [BYTE_W-1:0] b;
        b = b_in;
        case (rx_phase)
            PH_WAIT: begin
                if (b == SYNC_B0) rx_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (b == SYNC_B1) rx_phase = PH_SYNC3;
                else if (b != SYNC_B0) rx_phase = PH_WAIT;
            end
            PH_SYNC3: begin
                if (b == SYNC_B2) rx_phase = PH_HDR0;
                else if (b == SYNC_B0) rx_phase = PH_SYNC2;
            end
            PH_HDR0: begin
                if (b == HDR0_VAL) begin
                    rx_phase = PH_HDR1;
                end else begin
                    rx_phase = PH_SKIP;
                    skip_cnt = SKIP_AFTER_HDR0;
                end
                sum_run = {8'h00, b};
                crc_run = crc_step(16'h0000, b);
            end
            PH_HDR1: begin
                if (b[7:4] == HDR1_HI) begin
                    rx_phase = PH_CH3HI;
                end else begin
                    rx_phase = PH_SKIP;
                    skip_cnt = SKIP_AFTER_HDR1;
                end
                sum_run = sum_run + {8'h00, b};
                crc_run = crc_step(crc_run, b);
            end
            PH_CH3HI, PH_P6, PH_P7, PH_CH3LO: begin
                if (rx_phase == PH_CH3HI) b = {b[7:4], ch3_word[11:8]};
                if (rx_phase == PH_CH3LO) b = ch3_word[7:0];
                rx_phase = t_phase'(rx_phase + 4'd1);
                sum_run  = sum_run + {8'h00, b};
                crc_run  = crc_step(crc_run, b);
            end
            PH_CRCH: begin
                b        = crc_run[15:8];
                rx_phase = PH_CRCL;
                sum_run  = sum_run + {8'h00, b};
            end
            PH_CRCL: begin
                b        = crc_run[7:0];
                rx_phase = PH_G1;
                sum_run  = sum_run + {8'h00, b};
            end
            PH_G1: rx_phase = PH_G2;
            PH_G2: rx_phase = PH_SUMH;
            PH_SUMH: begin
                b        = sum_run[15:8];
                rx_phase = PH_SUML;
            end
            PH_SUML: begin
                b           = sum_run[7:0];
                rx_phase    = PH_WAIT;
                frames_seen = frames_seen + 4'd1;
                if (frames_seen >= update_every) begin
                    frames_seen = 4'd0;
                    ch3_word    = next_channel();
                end
                key_latch = key_latch | keys;
            end
            default: begin
                skip_cnt = skip_cnt - 4'd1;
                if (skip_cnt == 4'd0) rx_phase = PH_WAIT;
            end
        endcase
        return b;
    endfunction

    function automatic logic [KEY_W-1:0] key_pattern();
        case ($urandom_range(0, 3))
            0: return KEY_W'($urandom);
            1: return KEY_W'(1) << $urandom_range(0, KEY_W - 1);
            default: return '0;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] noise_byte();
        case ($urandom_range(0, 3))
            0: return SYNC_B0;
            1: return SYNC_B1;
            2: return SYNC_B2;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic [KEY_W-1:0] k,
                             input logic known, input logic [BYTE_W-1:0] known_val);
        logic [BYTE_W-1:0] want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_byte_in  = b;
        i_key_bits = k;
        do @(posedge i_clk); while (o_in_stall);
        want = rewrite_byte(b, k);
        expected_bytes.push_back(known ? known_val : want);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_random(input int n_items);
        int                sent;
        int                kind;
        int                len;
        logic [BYTE_W-1:0] b;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind <= 8) begin
                push_byte(SYNC_B0, key_pattern(), 1'b0, 8'h00);
                push_byte(SYNC_B1, key_pattern(), 1'b0, 8'h00);
                push_byte(SYNC_B2, key_pattern(), 1'b0, 8'h00);
                b = HDR0_VAL;
                if (kind == 7) begin
                    b = BYTE_W'($urandom);
                    if (b == HDR0_VAL) b = ~b;
                end
                push_byte(b, key_pattern(), 1'b0, 8'h00);
                b = {HDR1_HI, 4'($urandom)};
                if (kind == 8) begin
                    b = BYTE_W'($urandom);
                    if (b[7:4] == HDR1_HI) b[7] = 1'b0;
                end
                push_byte(b, key_pattern(), 1'b0, 8'h00);
                repeat (10) push_byte(BYTE_W'($urandom), key_pattern(), 1'b0, 8'h00);
                sent += 15;
            end else begin
                len = $urandom_range(1, 6);
                repeat (len) push_byte(noise_byte(), key_pattern(), 1'b0, 8'h00);
                sent += len;
            end
        end
    endtask

    // Write only with nothing in flight
    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
        while (expected_bytes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_SYNC_VALUE) sync_raw = val;
        else if (idx == CFG_FRAMES_PER_UPDATE) update_every = val[FPU_W-1:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall = ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_out
        logic [BYTE_W-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                $error("byte_out with no item expected: actual %02h", o_byte_out);
                mismatch_cnt++;
            end else begin
                want = expected_bytes.pop_front();
                if (o_byte_out !== want) begin
                    $error("byte_out mismatch: expected %02h, actual %02h", want, o_byte_out);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                     || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_byte_in      = '0;
        i_key_bits     = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        send_idle_pct  = 15;
        recv_stall_pct = 63;
        rx_phase       = PH_WAIT;
        skip_cnt       = '0;
        sum_run        = '0;
        crc_run        = '0;
        ch3_word       = CHANNEL_WORD_RST;
        frames_seen    = '0;
        seq_slot       = '0;
        key_latch      = '0;
        sync_raw       = SYNC_VALUE_RST;
        update_every   = FPU_RST;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            push_byte(DIR_ROWS[r].din, DIR_ROWS[r].keys, DIR_ROWS[r].known, DIR_ROWS[r].dout);
        end
        send_random(150);

        // sync value past the top saturates to zero; advance on every frame
        set_register(CFG_SYNC_VALUE, 12'hfff);
        set_register(CFG_FRAMES_PER_UPDATE, 12'h000);
        set_register(CFG_IDX_SPARE2, CFG_DATA_W'($urandom));
        set_register(CFG_IDX_SPARE3, CFG_DATA_W'($urandom));
        send_idle_pct  = 63;
        recv_stall_pct = 15;
        send_random(150);

        set_register(CFG_SYNC_VALUE, 12'(CH_RAW_MAX));
        set_register(CFG_FRAMES_PER_UPDATE, 12'h001);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(100);

        set_register(CFG_SYNC_VALUE, 12'h000);
        set_register(CFG_FRAMES_PER_UPDATE, 12'h00f);
        send_random(175);

        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
